@@ rtl/lz77d_pkg.sv @@
// Shared types and constants for the LZ77 type 0x10 stream decompressor.
package lz77d_pkg;

   // Header type byte and field sizes of the compressed format.
   localparam logic [7:0] TYPE_ID       = 8'h10;
   localparam int         HDR_LEN_BITS  = 24;
   localparam int         DIST_BITS     = 13;
   localparam int         RUN_BITS      = 5;
   localparam logic [3:0] FLAG_COUNT    = 4'd8;
   localparam logic [4:0] MIN_MATCH     = 5'd3;

   // Error codes reported on the result channel.
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TYPE = 2'd1;
   localparam logic [1:0] ERR_DIST = 2'd2;

   // Input transaction: one compressed byte.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_start;
   } req_type;

   // Result transaction: one decompressed byte with status.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_done;
      logic [1:0] error;
   } rsp_type;

endpackage

@@ rtl/lz77_type10_stream_decompressor.sv @@
// Top level of the LZ77 type 0x10 stream decompressor.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   lz77d_pkg::req_type (in_byte, stream_start)
//   rsp_      out        rsp_valid/rsp_ready   lz77d_pkg::rsp_type (out_byte, status)
//
// Header, flag, token-high and literal bytes are each handled on acceptance. A token's low
// byte is followed by the distance check state and then the copy state, which emits each
// copied byte (up to 18, fewer where the declared length cuts the copy short),
// paced by the single read port of the window RAM.
// Reset clears the parser and the length, byte and flag counters, not the history window.
// A stalled result register holds the parser and the copy engine in place.
module lz77_type10_stream_decompressor #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int LENGTH_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lz77d_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lz77d_pkg::rsp_type rsp_data
);
   import lz77d_pkg::*;

   localparam int ADDR_BITS = $clog2(WINDOW_DEPTH);

   typedef enum logic [9:0] {
      ST_TYPE  = 10'b00_0000_0001,
      ST_LEN0  = 10'b00_0000_0010,
      ST_LEN1  = 10'b00_0000_0100,
      ST_LEN2  = 10'b00_0000_1000,
      ST_DATA  = 10'b00_0001_0000,
      ST_TOKLO = 10'b00_0010_0000,
      ST_CHECK = 10'b00_0100_0000,
      ST_COPY  = 10'b00_1000_0000,
      ST_DONE  = 10'b01_0000_0000,
      ST_FAIL  = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [LENGTH_BITS-1:0] decl_ff, decl_in;
   logic [LENGTH_BITS-1:0] prod_ff, prod_in;
   logic [7:0]             flags_ff, flags_in;
   logic [3:0]             flags_left_ff, flags_left_in;
   logic [7:0]             tok_high_ff, tok_high_in;
   logic [DIST_BITS-1:0]   dist_ff, dist_in;
   logic [RUN_BITS-1:0]    run_ff, run_in;
   logic [ADDR_BITS-1:0]   src_ff, src_in;
   logic                   fwd_ff, fwd_in;
   logic [7:0]             fwd_data_ff, fwd_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   slot_ok;
   logic                   req_fire;
   state_type              phase;
   logic                   wr_en;
   logic [7:0]             wr_data;
   logic                   rd_en;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [7:0]             ram_q;
   logic [7:0]             copy_byte;
   logic [LENGTH_BITS-1:0] prod_next;
   logic                   done_now;
   logic [HDR_LEN_BITS-1:0] full_len;
   logic [LENGTH_BITS-1:0] dist_ext;
   logic                   run_last;

   // History window.
   lz77d_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (prod_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // The result register can take a new transaction this cycle.
   assign slot_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff != ST_CHECK) && (state_ff != ST_COPY) && slot_ok;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared helpers for producing one byte.
   assign prod_next = prod_ff + LENGTH_BITS'(1);
   assign done_now  = (prod_next >= decl_ff);
   assign full_len  = {req_data.in_byte, decl_ff[15:0]};
   assign dist_ext  = LENGTH_BITS'(dist_ff);
   assign copy_byte = fwd_ff ? fwd_data_ff : ram_q;
   assign run_last  = (run_ff == RUN_BITS'(1)) || done_now;
   assign phase     = req_data.stream_start ? ST_TYPE : state_ff;

   // Parser and copy engine.
   always_comb begin
      state_in      = state_ff;
      decl_in       = decl_ff;
      prod_in       = prod_ff;
      flags_in      = flags_ff;
      flags_left_in = flags_left_ff;
      tok_high_in   = tok_high_ff;
      dist_in       = dist_ff;
      run_in        = run_ff;
      src_in        = src_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_data       = req_data.in_byte;
      rd_en         = 1'b0;
      rd_addr       = src_ff;

      if (req_fire) begin
         case (phase)
            ST_TYPE: begin
               decl_in       = '0;
               prod_in       = '0;
               flags_in      = '0;
               flags_left_in = '0;
               tok_high_in   = '0;
               if (req_data.in_byte != TYPE_ID) begin
                  state_in     = ST_FAIL;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_byte: 8'd0, last_of_run: 1'b1,
                                   stream_done: 1'b0, error: ERR_TYPE};
               end else begin
                  state_in = ST_LEN0;
               end
            end
            ST_LEN0: begin
               decl_in  = LENGTH_BITS'(req_data.in_byte);
               state_in = ST_LEN1;
            end
            ST_LEN1: begin
               decl_in  = decl_ff | (LENGTH_BITS'(req_data.in_byte) << 8);
               state_in = ST_LEN2;
            end
            ST_LEN2: begin
               decl_in  = full_len[LENGTH_BITS-1:0];
               state_in = (full_len[LENGTH_BITS-1:0] == '0) ? ST_DONE : ST_DATA;
            end
            ST_DATA: begin
               if (flags_left_ff == '0) begin
                  flags_in      = req_data.in_byte;
                  flags_left_in = FLAG_COUNT;
               end else begin
                  flags_in      = {flags_ff[6:0], 1'b0};
                  flags_left_in = flags_left_ff - 4'd1;
                  if (flags_ff[7]) begin
                     tok_high_in = req_data.in_byte;
                     state_in    = ST_TOKLO;
                  end else begin
                     // Literal byte goes to the window and to the output.
                     wr_en        = 1'b1;
                     prod_in      = prod_next;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte: req_data.in_byte, last_of_run: 1'b1,
                                      stream_done: done_now, error: ERR_NONE};
                     if (done_now) begin
                        state_in = ST_DONE;
                     end
                  end
               end
            end
            ST_TOKLO: begin
               dist_in  = {1'b0, tok_high_ff[3:0], req_data.in_byte} + DIST_BITS'(1);
               run_in   = RUN_BITS'(tok_high_ff[7:4]) + MIN_MATCH;
               state_in = ST_CHECK;
            end
            default: begin
               // Finished or failed stream: bytes are dropped.
            end
         endcase
      end else if (state_ff == ST_CHECK) begin
         if (slot_ok) begin
            if (dist_ext > prod_ff) begin
               state_in     = ST_FAIL;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: 8'd0, last_of_run: 1'b1,
                                stream_done: 1'b0, error: ERR_DIST};
            end else begin
               // First window read of the copy.
               rd_en    = 1'b1;
               rd_addr  = prod_ff[ADDR_BITS-1:0] - dist_ff[ADDR_BITS-1:0];
               src_in   = rd_addr + ADDR_BITS'(1);
               fwd_in   = 1'b0;
               state_in = ST_COPY;
            end
         end
      end else if (state_ff == ST_COPY) begin
         if (slot_ok) begin
            // Emit the byte from the previous read (or forwarded) and write it back to the window.
            wr_en        = 1'b1;
            wr_data      = copy_byte;
            prod_in      = prod_next;
            run_in       = run_ff - RUN_BITS'(1);
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{out_byte: copy_byte, last_of_run: run_last,
                             stream_done: done_now, error: ERR_NONE};
            if (run_last) begin
               state_in = done_now ? ST_DONE : ST_DATA;
            end else begin
               // Next read; a distance of one reads the entry written now.
               rd_en       = 1'b1;
               rd_addr     = src_ff;
               src_in      = src_ff + ADDR_BITS'(1);
               fwd_in      = (src_ff == prod_ff[ADDR_BITS-1:0]);
               fwd_data_in = copy_byte;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_TYPE;
         decl_ff       <= '0;
         prod_ff       <= '0;
         flags_ff      <= '0;
         flags_left_ff <= '0;
         tok_high_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         decl_ff       <= decl_in;
         prod_ff       <= prod_in;
         flags_ff      <= flags_in;
         flags_left_ff <= flags_left_in;
         tok_high_ff   <= tok_high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      run_ff      <= run_in;
      src_ff      <= src_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/lz77d_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module lz77d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port that holds its data while not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/lz77_type10_stream_decompressor_tb.sv @@
// Self-checking testbench for the LZ77 type 0x10 stream decompressor.
`timescale 1ns / 1ps

module lz77_type10_stream_decompressor_tb;
   import lz77d_pkg::*;

   localparam int WIN_SIZE    = 4096;
   localparam int ITEM_TARGET = 400;
   localparam int DRAIN_WAIT  = 64;
   localparam int CYCLE_LIMIT = 600000;

   // Decoder phases of the predictor.
   typedef enum logic [2:0] {
      P_TYPE, P_LEN0, P_LEN1, P_LEN2, P_DATA, P_TOKLO, P_DONE
   } parse_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Compressed bytes waiting to be sent and decompressed bytes still due.
   req_type compressed_q[$];
   rsp_type expected_bytes[$];
   int      total_items = 0;
   int      sent_n      = 0;
   int      mismatches  = 0;
   int      cycles      = 0;
   rsp_type head_exp;

   // Predictor state.
   logic [7:0]      win_mem [WIN_SIZE];
   parse_phase_type phase;
   logic [23:0]     decl_len;
   logic [23:0]     made_cnt;
   logic [7:0]      flag_reg;
   logic [3:0]      flags_left;
   logic [7:0]      tok_hi;
   logic            failed;

   lz77_type10_stream_decompressor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void clear_parser();
      phase      = P_TYPE;
      decl_len   = '0;
      made_cnt   = '0;
      flag_reg   = '0;
      flags_left = '0;
      tok_hi     = '0;
      failed     = 1'b0;
   endfunction

   function automatic void push_expect(logic [7:0] b, logic last, logic done,
                                       logic [1:0] err);
      rsp_type r;
      r.out_byte    = b;
      r.last_of_run = last;
      r.stream_done = done;
      r.error       = err;
      expected_bytes.push_back(r);
   endfunction

   // Writes one output byte to the window and queues it as expected.
   function automatic void emit_byte(logic [7:0] v, logic last);
      logic done;
      win_mem[made_cnt[11:0]] = v;
      made_cnt = made_cnt + 24'd1;
      done = (made_cnt >= decl_len);
      push_expect(v, last, done, ERR_NONE);
      if (done) begin
         phase = P_DONE;
      end
   endfunction

   // Works out the decompressed bytes caused by one accepted input transaction.
   function automatic void decode_byte(req_type t);
      logic [7:0]  b;
      logic [11:0] addr;
      int unsigned run;
      int unsigned back;
      int unsigned n;
      b = t.in_byte;
      if (t.stream_start) begin
         clear_parser();
      end
      if (failed || phase == P_DONE) begin
         return;
      end
      case (phase)
         P_TYPE: begin
            if (b != TYPE_ID) begin
               failed = 1'b1;
               push_expect(8'h00, 1'b1, 1'b0, ERR_TYPE);
            end else begin
               phase = P_LEN0;
            end
         end
         P_LEN0: begin
            decl_len = {16'h0000, b};
            phase    = P_LEN1;
         end
         P_LEN1: begin
            decl_len[15:8] = b;
            phase          = P_LEN2;
         end
         P_LEN2: begin
            decl_len[23:16] = b;
            phase = (decl_len == 24'd0) ? P_DONE : P_DATA;
         end
         P_DATA: begin
            if (flags_left == 4'd0) begin
               flag_reg   = b;
               flags_left = FLAG_COUNT;
            end else begin
               flags_left = flags_left - 4'd1;
               if (flag_reg[7]) begin
                  tok_hi = b;
                  phase  = P_TOKLO;
               end else begin
                  emit_byte(b, 1'b1);
               end
               flag_reg = {flag_reg[6:0], 1'b0};
            end
         end
         P_TOKLO: begin
            run   = 3 + tok_hi[7:4];
            back  = 1 + {tok_hi[3:0], b};
            phase = P_DATA;
            if (back > made_cnt) begin
               failed = 1'b1;
               push_expect(8'h00, 1'b1, 1'b0, ERR_DIST);
            end else begin
               // The copy is cut off at the declared length.
               n = 32'(decl_len - made_cnt);
               if (run < n) begin
                  n = run;
               end
               for (int i = 0; i < n; i++) begin
                  addr = 12'(made_cnt - back);
                  emit_byte(win_mem[addr], i == n - 1);
               end
            end
         end
         default: begin
            phase = P_TYPE;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   task automatic put(logic [7:0] b, logic s);
      req_type t;
      t.in_byte      = b;
      t.stream_start = s;
      compressed_q.push_back(t);
   endtask

   // Bytes that arrive after a stream has ended or failed.
   task automatic add_noise(int unsigned n);
      for (int i = 0; i < n; i++) begin
         put(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // Builds one stream with valid back references unless an error is injected.
   // The stream is abandoned once about cut body bytes have been sent.
   task automatic add_stream(logic [23:0] decl, int unsigned tok_pct,
                             int unsigned err_pct, int unsigned min_run,
                             int unsigned cut);
      req_type     grp[$];
      logic [7:0]  flags;
      logic [11:0] dm;
      logic [3:0]  rl;
      req_type     t;
      int unsigned made;
      int unsigned sent;
      int unsigned run;
      int unsigned back;
      int unsigned lim;
      bit          bad;
      put(TYPE_ID, 1'b1);
      put(decl[7:0], 1'b0);
      put(decl[15:8], 1'b0);
      put(decl[23:16], 1'b0);
      made = 0;
      sent = 0;
      bad  = 1'b0;
      while (made < decl && sent < cut && !bad) begin
         grp.delete();
         flags = 8'($urandom_range(255));
         for (int k = 7; k >= 0; k--) begin
            if (made >= decl) begin
               break;
            end
            t.stream_start = 1'b0;
            if (made > 0 && $urandom_range(99) < tok_pct) begin
               flags[k] = 1'b1;
               run = $urandom_range(18, min_run);
               lim = (made < WIN_SIZE) ? made : WIN_SIZE;
               if (made < WIN_SIZE && $urandom_range(99) < err_pct) begin
                  back = $urandom_range(WIN_SIZE, made + 1);
                  bad  = 1'b1;
               end else if ($urandom_range(1) == 0) begin
                  // Short distances give overlapping copies.
                  back = $urandom_range((lim < 8) ? lim : 8, 1);
               end else begin
                  back = $urandom_range(lim, 1);
               end
               rl = 4'(run - 3);
               dm = 12'(back - 1);
               t.in_byte = {rl, dm[11:8]};
               grp.push_back(t);
               t.in_byte = dm[7:0];
               grp.push_back(t);
               if (bad) begin
                  break;
               end
               made += (run < decl - made) ? run : decl - made;
            end else begin
               flags[k] = 1'b0;
               t.in_byte = 8'($urandom_range(255));
               grp.push_back(t);
               made++;
            end
         end
         put(flags, 1'b0);
         foreach (grp[i]) begin
            compressed_q.push_back(grp[i]);
         end
         sent += 1 + grp.size();
      end
      if (made >= decl || bad) begin
         if ($urandom_range(99) < 30) begin
            add_noise($urandom_range(3, 1));
         end
      end
   endtask

   initial begin
      int unsigned pick;
      logic [7:0]  b;

      // Type byte taken without a start marker right after reset; a token
      // copy that runs past the declared length; a trailing ignored byte.
      put(TYPE_ID, 1'b0);
      put(8'h05, 1'b0);
      put(8'h00, 1'b0);
      put(8'h00, 1'b0);
      put(8'h40, 1'b0);
      put(8'hFF, 1'b0);
      put(8'hF0, 1'b0);
      put(8'h00, 1'b0);
      add_noise(1);
      // Wrong type byte; the following byte is ignored.
      put(8'h11, 1'b1);
      add_noise(1);
      // Zero declared length.
      put(TYPE_ID, 1'b1);
      put(8'h00, 1'b0);
      put(8'h00, 1'b0);
      put(8'h00, 1'b0);
      add_noise(1);
      // Longest token with the largest distance before anything was produced.
      put(TYPE_ID, 1'b1);
      put(8'h03, 1'b0);
      put(8'h00, 1'b0);
      put(8'h00, 1'b0);
      put(8'h80, 1'b0);
      put(8'hFF, 1'b0);
      put(8'hFF, 1'b0);

      // One long stream with long copies and far back references.
      add_stream(24'(1500 + $urandom_range(100)), 90, 0, 16, 32'hFFFF_FFFF);

      while (compressed_q.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            add_stream(24'($urandom_range(40, 1)), 40, 0, 3, 32'hFFFF_FFFF);
         end else if (pick < 60) begin
            add_stream(24'($urandom_range(200, 41)), 50, 0, 3, 32'hFFFF_FFFF);
         end else if (pick < 72) begin
            add_stream(24'($urandom_range(60, 1)), 40, 25, 3, 32'hFFFF_FFFF);
         end else if (pick < 82) begin
            // Large declared length, cut short by the next stream start.
            add_stream(24'($urandom_range(24'hFF_FFFF, 1)), 40, 0, 3,
                       $urandom_range(30, 5));
         end else if (pick < 88) begin
            b = 8'($urandom_range(255));
            if (b == TYPE_ID) begin
               b = b ^ 8'h01;
            end
            put(b, 1'b1);
            add_noise($urandom_range(3, 1));
         end else if (pick < 93) begin
            put(TYPE_ID, 1'b1);
            put(8'h00, 1'b0);
            put(8'h00, 1'b0);
            put(8'h00, 1'b0);
            add_noise($urandom_range(2));
         end else begin
            // Restart while the decoder waits for a token's second byte.
            put(TYPE_ID, 1'b1);
            put(8'h14, 1'b0);
            put(8'h00, 1'b0);
            put(8'h00, 1'b0);
            put(8'h40, 1'b0);
            put(8'($urandom_range(255)), 1'b0);
            put(8'($urandom_range(255)), 1'b0);
         end
      end
      total_items = compressed_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (compressed_q.size() != 0 || req_valid || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatches += expected_bytes.size();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver and monitor
   // ---------------------------------------------------------------------

   // Idle percentage per side for the three parts of the run.
   function automatic int unsigned idle_pct(bit recv_side);
      int part;
      part = (total_items > 0) ? (sent_n * 3) / total_items : 0;
      case (part)
         0:       return recv_side ? 74 : 32;
         1:       return recv_side ? 32 : 74;
         default: return 0;
      endcase
   endfunction

   // Sends compressed bytes and predicts each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_parser();
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            sent_n++;
         end
         if (!req_valid || req_ready) begin
            if (compressed_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               req_valid <= 1'b1;
               req_data  <= compressed_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      if (mismatches < 10) begin
         $display("%s: expected byte %02h last %0b done %0b err %0d,",
                  what, want.out_byte, want.last_of_run, want.stream_done, want.error);
         $display("   got byte %02h last %0b done %0b err %0d",
                  got.out_byte, got.last_of_run, got.stream_done, got.error);
      end
      mismatches++;
   endtask

   // Compares every accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected transaction", '0, rsp_data);
            end else begin
               head_exp = expected_bytes.pop_front();
               if (rsp_data.out_byte !== head_exp.out_byte
                   || rsp_data.last_of_run !== head_exp.last_of_run
                   || rsp_data.stream_done !== head_exp.stream_done
                   || rsp_data.error !== head_exp.error) begin
                  report_mismatch("mismatch", head_exp, rsp_data);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

endmodule
